// File: rtl/hpk_pkg.sv
`default_nettype none

package hpk_pkg;

    // Parser phases
    typedef enum logic [2:0] {
        PH_FIRST     = 3'd0,
        PH_IDX_CONT  = 3'd1,
        PH_LEN_FIRST = 3'd2,
        PH_LEN_CONT  = 3'd3,
        PH_STRING    = 3'd4
    } hpk_phase_t;

    // Representation kinds held in state
    localparam logic [2:0] REP_INDEXED     = 3'd0;
    localparam logic [2:0] REP_LIT_INCR    = 3'd1;
    localparam logic [2:0] REP_LIT_WITHOUT = 3'd2;
    localparam logic [2:0] REP_LIT_NEVER   = 3'd3;
    localparam logic [2:0] REP_SIZE_UPDATE = 3'd4;

    // Event kinds on the result channel
    localparam logic [3:0] EV_INDEXED     = 4'd0;
    localparam logic [3:0] EV_NAME_LEN    = 4'd5;
    localparam logic [3:0] EV_VALUE_LEN   = 4'd6;
    localparam logic [3:0] EV_STRING_BYTE = 4'd7;
    localparam logic [3:0] EV_ERROR       = 4'd8;

    // Error codes
    localparam logic [1:0] ERR_NONE       = 2'd0;
    localparam logic [1:0] ERR_ZERO_INDEX = 2'd1;
    localparam logic [1:0] ERR_TRUNCATED  = 2'd2;
    localparam logic [1:0] ERR_OVERFLOW   = 2'd3;

    // Representation type bits of the first byte, and the continuation flag of integer bytes
    localparam logic [7:0] FIRST_INDEXED = 8'h80;
    localparam logic [7:0] FIRST_INCR    = 8'h40;
    localparam logic [7:0] FIRST_SIZE    = 8'h20;
    localparam logic [7:0] FIRST_NEVER   = 8'h10;
    localparam logic [7:0] CONT_FLAG     = 8'd128;

    typedef struct packed {
        logic [3:0]  event_kind;
        logic [31:0] number;
        logic        huffman_coded;
        logic [7:0]  data_byte;
        logic        string_last;
        logic        field_done;
        logic [1:0]  error_code;
        logic        run_last;
    } hpk_result_t;

    // Results produced for one byte, first slot delivered first
    typedef struct packed {
        logic [1:0]  cnt;
        hpk_result_t res_a;
        hpk_result_t res_b;
    } hpk_push_t;

    // Low mask of an N-bit prefix
    function automatic logic [7:0] prefix_mask(input logic [2:0] bits);
        logic [7:0] m;
        case (bits)
            3'd0:    m = 8'd0;
            3'd1:    m = 8'd1;
            3'd2:    m = 8'd3;
            3'd3:    m = 8'd7;
            3'd4:    m = 8'd15;
            3'd5:    m = 8'd31;
            3'd6:    m = 8'd63;
            3'd7:    m = 8'd127;
            default: m = 8'd255;
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

// File: rtl/hpk_byte_if.sv
`default_nettype none

interface hpk_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       block_end;

    modport source (output valid, output in_byte, output block_end, input ready);
    modport sink   (input valid, input in_byte, input block_end, output ready);
endinterface

`default_nettype wire

// File: rtl/hpk_result_if.sv
`default_nettype none

interface hpk_result_if;
    logic        valid;
    logic        ready;
    logic [3:0]  event_kind;
    logic [31:0] number;
    logic        huffman_coded;
    logic [7:0]  data_byte;
    logic        string_last;
    logic        field_done;
    logic [1:0]  error_code;
    logic        run_last;

    modport source (
        output valid, output event_kind, output number, output huffman_coded,
        output data_byte, output string_last, output field_done,
        output error_code, output run_last, input ready
    );
    modport sink (
        input valid, input event_kind, input number, input huffman_coded,
        input data_byte, input string_last, input field_done,
        input error_code, input run_last, output ready
    );
endinterface

`default_nettype wire

// File: rtl/hpk_parse_core.sv
`default_nettype none

module hpk_parse_core
    import hpk_pkg::*;
#(
    parameter int INT_WIDTH = 32
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    input  wire logic [7:0] in_byte,
    input  wire logic       block_end,
    output logic            in_ready,
    input  wire logic       space_ok,
    output hpk_push_t       push
);

    localparam int NUM_BITS = (INT_WIDTH < 32) ? INT_WIDTH : 32;

    // Input register
    logic       in_valid_reg;
    logic [7:0] byte_reg;
    logic       end_reg;

    // Parse state
    hpk_phase_t  phase_reg, phase_next;
    logic [2:0]  kind_reg, kind_next;
    logic [31:0] accum_reg, accum_next;
    logic [5:0]  shift_reg, shift_next;
    logic [31:0] left_reg, left_next;
    logic        huff_reg, huff_next;
    logic        in_name_reg, in_name_next;
    logic        discard_reg, discard_next;

    logic        step;
    logic        v0;
    logic        v1;
    hpk_result_t res0;
    hpk_result_t trunc;

    // Integer decode scratch
    logic        fin;
    logic        is_len;
    logic        clr;
    logic [31:0] val;
    logic [7:0]  mask;
    logic [7:0]  masked;
    logic [6:0]  digit;
    logic [39:0] sum;
    logic        ovf;
    logic [31:0] left_dec;
    logic        last;

    assign step     = in_valid_reg && space_ok;
    assign in_ready = !in_valid_reg || step;

    // Hold the incoming byte until the parser takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            byte_reg <= in_byte;
            end_reg  <= block_end;
        end
    end

    // Decode one byte against the current state
    always_comb
    begin
        phase_next   = phase_reg;
        kind_next    = kind_reg;
        accum_next   = accum_reg;
        shift_next   = shift_reg;
        left_next    = left_reg;
        huff_next    = huff_reg;
        in_name_next = in_name_reg;
        discard_next = discard_reg;
        v0           = 1'b0;
        v1           = 1'b0;
        res0         = '0;
        trunc        = '0;
        fin          = 1'b0;
        is_len       = 1'b0;
        clr          = 1'b0;
        val          = 32'd0;
        mask         = 8'd0;
        masked       = 8'd0;
        digit        = byte_reg[6:0];
        sum          = 40'd0;
        ovf          = 1'b0;
        left_dec     = left_reg - 32'd1;
        last         = (left_dec == 32'd0);

        if (step && !discard_reg)
        begin
            case (phase_reg)
                PH_IDX_CONT, PH_LEN_CONT:
                begin
                    is_len = (phase_reg == PH_LEN_CONT);
                    if (digit != 7'd0)
                    begin
                        sum = {8'd0, accum_reg} + ({33'd0, digit} << shift_reg);
                        if ({26'd0, shift_reg} >= NUM_BITS)
                        begin
                            ovf = 1'b1;
                        end
                        else if ((sum >> NUM_BITS) != 40'd0)
                        begin
                            ovf = 1'b1;
                        end
                        else
                        begin
                            accum_next = sum[31:0];
                        end
                    end
                    if (ovf)
                    begin
                        v0   = 1'b1;
                        res0.event_kind = EV_ERROR;
                        res0.error_code = ERR_OVERFLOW;
                        clr  = 1'b1;
                        discard_next = 1'b1;
                    end
                    else
                    begin
                        shift_next = (shift_reg > 6'd56) ? 6'd63 : shift_reg + 6'd7;
                        if ((byte_reg & CONT_FLAG) == 8'd0)
                        begin
                            fin = 1'b1;
                            val = accum_next;
                        end
                    end
                end
                PH_LEN_FIRST:
                begin
                    is_len    = 1'b1;
                    huff_next = byte_reg[7];
                    mask      = prefix_mask(3'd7);
                end
                PH_STRING:
                begin
                    v0 = 1'b1;
                    res0.event_kind    = EV_STRING_BYTE;
                    res0.huffman_coded = huff_reg;
                    res0.data_byte     = byte_reg;
                    res0.string_last   = last;
                    res0.field_done    = last && !in_name_reg;
                    left_next = left_dec;
                    if (last)
                    begin
                        if (in_name_reg)
                        begin
                            in_name_next = 1'b0;
                            phase_next   = PH_LEN_FIRST;
                        end
                        else
                        begin
                            clr = 1'b1;
                        end
                    end
                end
                default:
                begin
                    if ((byte_reg & FIRST_INDEXED) != 8'd0)
                    begin
                        kind_next = REP_INDEXED;
                        mask      = prefix_mask(3'd7);
                    end
                    else if ((byte_reg & FIRST_INCR) != 8'd0)
                    begin
                        kind_next = REP_LIT_INCR;
                        mask      = prefix_mask(3'd6);
                    end
                    else if ((byte_reg & FIRST_SIZE) != 8'd0)
                    begin
                        kind_next = REP_SIZE_UPDATE;
                        mask      = prefix_mask(3'd5);
                    end
                    else if ((byte_reg & FIRST_NEVER) != 8'd0)
                    begin
                        kind_next = REP_LIT_NEVER;
                        mask      = prefix_mask(3'd4);
                    end
                    else
                    begin
                        kind_next = REP_LIT_WITHOUT;
                        mask      = prefix_mask(3'd4);
                    end
                end
            endcase

            // Prefix integer: finish now or continue over further bytes
            if (phase_reg == PH_FIRST || phase_reg == PH_LEN_FIRST)
            begin
                masked = byte_reg & mask;
                if (masked != mask)
                begin
                    fin = 1'b1;
                    val = {24'd0, masked};
                end
                else
                begin
                    accum_next = {24'd0, mask};
                    shift_next = 6'd0;
                    phase_next = is_len ? PH_LEN_CONT : PH_IDX_CONT;
                end
            end

            // Act on a completed integer
            if (fin)
            begin
                accum_next = 32'd0;
                shift_next = 6'd0;
                v0 = 1'b1;
                res0.number = val;
                if (!is_len)
                begin
                    res0.event_kind = {1'b0, kind_next};
                    if (kind_next == REP_INDEXED)
                    begin
                        if (val == 32'd0)
                        begin
                            res0.event_kind = EV_ERROR;
                            res0.number     = 32'd0;
                            res0.error_code = ERR_ZERO_INDEX;
                            discard_next    = 1'b1;
                        end
                        else
                        begin
                            res0.field_done = 1'b1;
                        end
                        clr = 1'b1;
                    end
                    else if (kind_next == REP_SIZE_UPDATE)
                    begin
                        res0.field_done = 1'b1;
                        clr = 1'b1;
                    end
                    else
                    begin
                        in_name_next = (val == 32'd0);
                        phase_next   = PH_LEN_FIRST;
                    end
                end
                else if (in_name_reg)
                begin
                    res0.event_kind    = EV_NAME_LEN;
                    res0.huffman_coded = huff_next;
                    if (val == 32'd0)
                    begin
                        in_name_next = 1'b0;
                        phase_next   = PH_LEN_FIRST;
                    end
                    else
                    begin
                        left_next  = val;
                        phase_next = PH_STRING;
                    end
                end
                else
                begin
                    res0.event_kind    = EV_VALUE_LEN;
                    res0.huffman_coded = huff_next;
                    res0.field_done    = (val == 32'd0);
                    if (val == 32'd0)
                    begin
                        clr = 1'b1;
                    end
                    else
                    begin
                        left_next  = val;
                        phase_next = PH_STRING;
                    end
                end
            end
        end

        // Drop the representation state
        if (clr)
        begin
            phase_next   = PH_FIRST;
            kind_next    = REP_INDEXED;
            accum_next   = 32'd0;
            shift_next   = 6'd0;
            left_next    = 32'd0;
            huff_next    = 1'b0;
            in_name_next = 1'b0;
        end

        // End of block: leave discard or flag truncation
        if (step && end_reg)
        begin
            if (discard_next)
            begin
                discard_next = 1'b0;
            end
            else if (phase_next != PH_FIRST)
            begin
                v1 = 1'b1;
                trunc.event_kind = EV_ERROR;
                trunc.error_code = ERR_TRUNCATED;
            end
            phase_next   = PH_FIRST;
            kind_next    = REP_INDEXED;
            accum_next   = 32'd0;
            shift_next   = 6'd0;
            left_next    = 32'd0;
            huff_next    = 1'b0;
            in_name_next = 1'b0;
        end
    end

    // Pack the results in delivery order
    always_comb
    begin
        push = '0;
        push.cnt = {1'b0, v0} + {1'b0, v1};
        push.res_b = trunc;
        push.res_b.run_last = 1'b1;
        if (v0)
        begin
            push.res_a = res0;
            push.res_a.run_last = !v1;
        end
        else
        begin
            push.res_a = trunc;
            push.res_a.run_last = 1'b1;
        end
    end

    // Advance the parse state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_FIRST;
            kind_reg    <= REP_INDEXED;
            accum_reg   <= 32'd0;
            shift_reg   <= 6'd0;
            left_reg    <= 32'd0;
            huff_reg    <= 1'b0;
            in_name_reg <= 1'b0;
            discard_reg <= 1'b0;
        end
        else if (step)
        begin
            phase_reg   <= phase_next;
            kind_reg    <= kind_next;
            accum_reg   <= accum_next;
            shift_reg   <= shift_next;
            left_reg    <= left_next;
            huff_reg    <= huff_next;
            in_name_reg <= in_name_next;
            discard_reg <= discard_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/hpk_result_fifo.sv
`default_nettype none

module hpk_result_fifo
    import hpk_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire hpk_push_t  push,
    output logic            space_ok,
    output logic            out_valid,
    input  wire logic       out_ready,
    output hpk_result_t     head
);

    hpk_result_t entry_reg [4];
    logic [1:0]  wr_reg, wr_next;
    logic [1:0]  rd_reg, rd_next;
    logic [2:0]  count_reg, count_next;
    logic        pop;

    // Room for the worst case of two results
    assign space_ok  = (count_reg <= 3'd2);
    assign out_valid = (count_reg != 3'd0);
    assign pop       = out_valid && out_ready;
    assign head      = entry_reg[rd_reg];

    always_comb
    begin
        wr_next    = wr_reg + push.cnt;
        rd_next    = rd_reg + {1'b0, pop};
        count_next = count_reg + {1'b0, push.cnt} - {2'd0, pop};
    end

    // Write up to two results per cycle
    always_ff @(posedge clk)
    begin
        if (push.cnt != 2'd0)
        begin
            entry_reg[wr_reg] <= push.res_a;
        end
        if (push.cnt == 2'd2)
        begin
            entry_reg[wr_reg + 2'd1] <= push.res_b;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= 2'd0;
            rd_reg    <= 2'd0;
            count_reg <= 3'd0;
        end
        else
        begin
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/hpack_representation_parser.sv
// HPACK representation parser: one header-block byte in, up to two results out.
// A transferred byte waits in the input register and its results go through the result queue.
// Throughput: one byte per cycle while the result queue has room for two results; a byte with
// two results (the block-end truncation error) is sent as two transfers on the single result port.
// Reset: rst_n clears the parse state, the input register and the result queue at once.
`default_nettype none

module hpack_representation_parser
    import hpk_pkg::*;
#(
    parameter int INT_WIDTH = 32
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    hpk_byte_if.sink     in_ch,
    hpk_result_if.source out_ch
);

    hpk_push_t   push;
    logic        space_ok;
    logic        out_valid;
    hpk_result_t head;

    hpk_parse_core #(
        .INT_WIDTH (INT_WIDTH)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_byte   (in_ch.in_byte),
        .block_end (in_ch.block_end),
        .in_ready  (in_ch.ready),
        .space_ok  (space_ok),
        .push      (push)
    );

    hpk_result_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .space_ok  (space_ok),
        .out_valid (out_valid),
        .out_ready (out_ch.ready),
        .head      (head)
    );

    // Drive the result channel from the queue head
    assign out_ch.valid         = out_valid;
    assign out_ch.event_kind    = head.event_kind;
    assign out_ch.number        = head.number;
    assign out_ch.huffman_coded = head.huffman_coded;
    assign out_ch.data_byte     = head.data_byte;
    assign out_ch.string_last   = head.string_last;
    assign out_ch.field_done    = head.field_done;
    assign out_ch.error_code    = head.error_code;
    assign out_ch.run_last      = head.run_last;

`ifndef SYNTHESIS
    // A push never lands on a full queue
    assert property (@(posedge clk) disable iff (!rst_n)
        (push.cnt != 2'd0) |-> space_ok)
        else $error("result push without queue space");

    // The second result of a byte is always the truncation error
    assert property (@(posedge clk) disable iff (!rst_n)
        (push.cnt == 2'd2) |-> (push.res_b.event_kind == EV_ERROR
            && push.res_b.error_code == ERR_TRUNCATED && !push.res_a.run_last))
        else $error("bad second result");

    // A single result closes its byte
    assert property (@(posedge clk) disable iff (!rst_n)
        (push.cnt == 2'd1) |-> push.res_a.run_last)
        else $error("single result without run_last");

    // Error results carry a code, others none
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((head.event_kind == EV_ERROR) == (head.error_code != ERR_NONE)))
        else $error("error code does not match event kind");
`endif

endmodule

`default_nettype wire
